FILE: hw/rtl/rdcps_pkg.sv
// rdcps_pkg: types, codes and lookup tables for the rx duty-cycle power saver
// used by rdcps_cfg, rdcps_step and rx_duty_cycle_power_saver_unit
// no dependencies
package rdcps_pkg;

  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd1;

  // register index, taken from paddr[2]
  localparam logic REG_SAVE_LEVEL = 1'b0;

  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_RX_ON    = 2'd1,
    PH_RX_OFF   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    PWR_NONE = 2'd0,
    PWR_UP   = 2'd1,
    PWR_DOWN = 2'd2
  } pwr_cmd_t;

  typedef enum logic [1:0] {
    CLK_NONE = 2'd0,
    CLK_ECO  = 2'd1,
    CLK_RUN  = 2'd2
  } clk_cmd_t;

  localparam logic FUNC_POLL  = 1'b0;
  localparam logic FUNC_FORCE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        new_state;
    logic              has_signal;
    logic              user_event;
    logic              other_busy;
    logic              hotspot_mode;
    logic              audio_busy;
  } in_item_t;

  typedef struct packed {
    logic       rx_on;
    logic [1:0] phase;
    logic [1:0] rx_power_cmd;
    logic       include_codec_chip;
    logic [1:0] clock_cmd;
    logic       postpone_rssi;
  } out_item_t;

  // level state handed from the register block to the step logic
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               pend_exit;
    logic [LEVEL_W-1:0] pend_level;
  } lvl_state_t;

  // sequencer state
  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] deadline;
    logic              codec_off;
  } seq_state_t;

  // idle time before saving: (12 - 2*min(level,4)) seconds
  function automatic logic [13:0] idle_ms(input logic [LEVEL_W-1:0] lvl);
    logic [13:0] r;
    case (lvl)
      3'd0:    r = 14'd12000;
      3'd1:    r = 14'd10000;
      3'd2:    r = 14'd8000;
      3'd3:    r = 14'd6000;
      default: r = 14'd4000;
    endcase
    return r;
  endfunction

  // receiver on time: 130 - 10*level
  function automatic logic [7:0] on_ms(input logic [LEVEL_W-1:0] lvl);
    logic [7:0] r;
    case (lvl)
      3'd0:    r = 8'd130;
      3'd1:    r = 8'd120;
      3'd2:    r = 8'd110;
      3'd3:    r = 8'd100;
      3'd4:    r = 8'd90;
      3'd5:    r = 8'd80;
      3'd6:    r = 8'd70;
      default: r = 8'd60;
    endcase
    return r;
  endfunction

  // receiver off time: on time shifted left by level-1 (level 0 never used)
  function automatic logic [11:0] off_ms(input logic [LEVEL_W-1:0] lvl);
    logic [11:0] r;
    case (lvl)
      3'd1:    r = 12'd120;
      3'd2:    r = 12'd220;
      3'd3:    r = 12'd400;
      3'd4:    r = 12'd720;
      3'd5:    r = 12'd1280;
      3'd6:    r = 12'd2240;
      3'd7:    r = 12'd3840;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/rdcps_cfg.sv
// rdcps_cfg: apb register block holding save_level and the pending
// level-zero exit; depends on rdcps_pkg
module rdcps_cfg
  import rdcps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready,
  input  phase_t             phase,
  input  logic               step_go,
  output lvl_state_t         lvl_st
);

  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               pend_r, pend_nxt;
  logic [LEVEL_W-1:0] pend_lvl_r, pend_lvl_nxt;
  logic               wr_en;
  logic [LEVEL_W-1:0] wr_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SAVE_LEVEL);
  assign wr_val = pwdata[LEVEL_W-1:0];

  always_comb begin
    level_nxt    = level_r;
    pend_nxt     = pend_r;
    pend_lvl_nxt = pend_lvl_r;
    if (step_go) begin
      pend_nxt = 1'b0;
    end
    if (wr_en && (wr_val != level_r)) begin
      level_nxt = wr_val;
      // dropping to level zero mid-save: return to inactive on next transaction
      if ((wr_val == '0) && !pend_r && (phase != PH_INACTIVE)) begin
        pend_nxt     = 1'b1;
        pend_lvl_nxt = level_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= LEVEL_RESET;
      pend_r     <= 1'b0;
      pend_lvl_r <= '0;
    end else begin
      level_r    <= level_nxt;
      pend_r     <= pend_nxt;
      pend_lvl_r <= pend_lvl_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SAVE_LEVEL) begin
      prdata[LEVEL_W-1:0] = level_r;
    end
  end

  assign lvl_st.level      = level_r;
  assign lvl_st.pend_exit  = pend_r;
  assign lvl_st.pend_level = pend_lvl_r;

endmodule

FILE: hw/rtl/rdcps_step.sv
// rdcps_step: combinational next-state and command logic for one poll or
// force transaction; depends on rdcps_pkg
module rdcps_step
  import rdcps_pkg::*;
(
  input  in_item_t   item,
  input  seq_state_t cur,
  input  lvl_state_t lvl_st,
  output seq_state_t nxt,
  output out_item_t  res
);

  phase_t             ph;
  phase_t             tgt;
  logic [TIME_W-1:0]  dl;
  logic               cod;
  pwr_cmd_t           rcmd;
  logic               rcodec;
  clk_cmd_t           ccmd;
  logic               rssi;
  logic               act;
  logic [LEVEL_W-1:0] lvl;
  logic [TIME_W-1:0]  now;

  assign act = item.has_signal || item.user_event || item.other_busy;
  assign lvl = lvl_st.level;
  assign now = item.now_ms;
  assign tgt = phase_t'(item.new_state);

  always_comb begin
    ph     = cur.phase;
    dl     = cur.deadline;
    cod    = cur.codec_off;
    rcmd   = PWR_NONE;
    rcodec = 1'b0;
    ccmd   = CLK_NONE;
    rssi   = 1'b0;

    // pending exit after level dropped to zero, with the old level
    if (lvl_st.pend_exit && (ph != PH_INACTIVE)) begin
      if (ph == PH_RX_OFF) begin
        rcmd   = PWR_UP;
        rcodec = cod;
        cod    = 1'b0;
      end
      ph = PH_INACTIVE;
      if (lvl_st.pend_level > 3'd1) begin
        ccmd = CLK_RUN;
      end
      dl = now + TIME_W'(idle_ms(lvl_st.pend_level));
    end

    if (item.func == FUNC_FORCE) begin
      if ((item.new_state <= PH_RX_OFF) && (tgt != ph)) begin
        if (ph == PH_RX_OFF) begin
          rcmd   = PWR_UP;
          rcodec = cod;
          cod    = 1'b0;
        end
        ph = tgt;
        if (tgt == PH_INACTIVE) begin
          if (lvl > 3'd1) begin
            ccmd = CLK_RUN;
          end
          dl = now + TIME_W'(idle_ms(lvl));
        end
      end
    end else if (!item.hotspot_mode || (ph != PH_INACTIVE)) begin
      if (act) begin
        if (ph != PH_INACTIVE) begin
          if (ph == PH_RX_OFF) begin
            rcmd   = PWR_UP;
            rcodec = cod;
            cod    = 1'b0;
          end
          if (lvl > 3'd1) begin
            ccmd = CLK_RUN;
          end
          ph = PH_INACTIVE;
        end
        dl = now + TIME_W'(idle_ms(lvl));
      end else if ((now >= dl) && (lvl != '0) && !item.audio_busy) begin
        unique case (ph)
          PH_INACTIVE: begin
            dl = now + TIME_W'(idle_ms(lvl));
            if (lvl > 3'd1) begin
              ccmd = CLK_ECO;
            end
            ph = PH_RX_ON;
          end
          PH_RX_ON: begin
            rcmd   = PWR_DOWN;
            rcodec = (lvl > 3'd1);
            cod    = rcodec;
            dl     = now + TIME_W'(off_ms(lvl));
            ph     = PH_RX_OFF;
          end
          default: begin
            rcmd   = PWR_UP;
            rcodec = cod;
            cod    = 1'b0;
            dl     = now + TIME_W'(on_ms(lvl));
            rssi   = 1'b1;
            ph     = PH_RX_ON;
          end
        endcase
      end
    end
  end

  assign nxt.phase     = ph;
  assign nxt.deadline  = dl;
  assign nxt.codec_off = cod;

  assign res.rx_on              = (ph != PH_RX_OFF);
  assign res.phase              = ph;
  assign res.rx_power_cmd       = rcmd;
  assign res.include_codec_chip = (rcmd != PWR_NONE) && rcodec;
  assign res.clock_cmd          = ccmd;
  assign res.postpone_rssi      = rssi;

endmodule

FILE: hw/rtl/rx_duty_cycle_power_saver_unit.sv
// rx_duty_cycle_power_saver_unit: top level of the receiver power-save sequencer
// holds input register, sequencer state and result register; instantiates
// rdcps_cfg and rdcps_step; depends on rdcps_pkg
//
//   channel  | ports                              | direction | payload
//   ---------+------------------------------------+-----------+------------
//   input    | in_valid, in_stall, in_data        | into unit | in_item_t
//   result   | out_valid, out_stall, out_data     | out unit  | out_item_t
//   config   | psel, penable, pwrite, paddr, ...  | apb slave | save_level
//
// one result transaction per input transaction, one transaction per cycle sustained while out_stall is low
// the accepted item is loaded into the input register, then passes through the single-pass
// step logic into the result register once that register is free or being drained
// the phase/deadline registers close the only loop; they update once per item
// synchronous active-low reset: phase inactive, deadline zero, codec powered,
//   save_level 1; no clearing pass
// out_stall holds the result register; the input register keeps accepting while
//   the result register is empty or being drained
module rx_duty_cycle_power_saver_unit
  import rdcps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  // input register
  logic       in_valid_r, in_valid_nxt;
  in_item_t   in_data_r;
  // result register
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;
  // sequencer state
  seq_state_t state_r;
  seq_state_t state_nxt;
  out_item_t  step_res;
  lvl_state_t lvl_st;
  logic       in_take;
  logic       step_go;

  // step fires when the input register holds an item and the result register is free or being taken this cycle
  assign step_go  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !step_go;
  assign in_take  = in_valid && !in_stall;

  rdcps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .phase   (state_r.phase),
    .step_go (step_go),
    .lvl_st  (lvl_st)
  );

  rdcps_step u_step (
    .item   (in_data_r),
    .cur    (state_r),
    .lvl_st (lvl_st),
    .nxt    (state_nxt),
    .res    (step_res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step_go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      state_r.phase      <= PH_INACTIVE;
      state_r.deadline   <= '0;
      state_r.codec_off  <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step_go) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (step_go) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // rx_on always agrees with the reported phase
  a_rx_on_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.rx_on == (out_data_r.phase != PH_RX_OFF)))
    else $error("rx_on disagrees with phase");

  // power down only ever lands in the rx-off phase
  a_down_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.rx_power_cmd == PWR_DOWN)) |->
      (out_data_r.phase == PH_RX_OFF))
    else $error("power down without rx-off phase");

  // rssi postponement comes only with a power up
  a_rssi_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.postpone_rssi) |-> (out_data_r.rx_power_cmd == PWR_UP))
    else $error("rssi postponed without power up");

  // codec flag only rides on a power command
  a_codec_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.include_codec_chip) |->
      (out_data_r.rx_power_cmd != PWR_NONE))
    else $error("codec flag without power command");

  // an empty result register never backs up the input side
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

FILE: tb/rdcps_checker.sv
`timescale 1ns / 1ps
// rdcps_checker: watches the input, result and config channels of the power saver,
//   predicts every result transaction and compares it field by field
// depends on rdcps_pkg
module rdcps_checker
  import rdcps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  input  logic [APB_W-1:0]   prdata,
  input  logic               pready,
  output int unsigned        mismatch_cnt,
  output int unsigned        pending
);

  localparam int unsigned MAX_REPORTS = 100;

  // predicted sequencer state
  logic [LEVEL_W-1:0] cur_level;
  phase_t             cur_phase;
  logic [TIME_W-1:0]  cur_deadline;
  logic               cur_codec_off;
  logic               exit_pending;
  logic [LEVEL_W-1:0] exit_level;

  // commands gathered during one step
  pwr_cmd_t rx_cmd;
  logic     rx_codec;
  clk_cmd_t ck_cmd;
  logic     rssi_restart;

  out_item_t awaited_results[$];

  function automatic logic [TIME_W-1:0] idle_time(input logic [LEVEL_W-1:0] l);
    int unsigned m;
    m = (l < 4) ? int'(l) : 4;
    return TIME_W'((12 - 2 * m) * 1000);
  endfunction

  function automatic void wake_receiver();
    rx_cmd        = PWR_UP;
    rx_codec      = cur_codec_off;
    cur_codec_off = 1'b0;
  endfunction

  function automatic void jump_phase(input phase_t tgt, input logic [LEVEL_W-1:0] l,
                                     input logic [TIME_W-1:0] now);
    if (cur_phase == tgt) return;
    if (cur_phase == PH_RX_OFF) wake_receiver();
    cur_phase = tgt;
    if (tgt == PH_INACTIVE) begin
      if (l > 1) ck_cmd = CLK_RUN;
      cur_deadline = now + idle_time(l);
    end
  endfunction

  function automatic void write_level(input logic [LEVEL_W-1:0] v);
    if (v != cur_level) begin
      if (v == '0 && !exit_pending && cur_phase != PH_INACTIVE) begin
        exit_pending = 1'b1;
        exit_level   = cur_level;
      end
      cur_level = v;
    end
  endfunction

  function automatic out_item_t next_power_result(input in_item_t it);
    out_item_t          r;
    logic               busy;
    logic [LEVEL_W-1:0] l;
    logic [TIME_W-1:0]  dwell;
    busy = it.has_signal | it.user_event | it.other_busy;
    l = cur_level;
    rx_cmd = PWR_NONE;
    rx_codec = 1'b0;
    ck_cmd = CLK_NONE;
    rssi_restart = 1'b0;
    // a level-zero exit left over from a register write goes first
    if (exit_pending) begin
      exit_pending = 1'b0;
      jump_phase(PH_INACTIVE, exit_level, it.now_ms);
    end
    if (it.func == FUNC_FORCE) begin
      if (it.new_state <= PH_RX_OFF) jump_phase(phase_t'(it.new_state), l, it.now_ms);
    end else if (!it.hotspot_mode || cur_phase != PH_INACTIVE) begin
      if (busy) begin
        if (cur_phase != PH_INACTIVE) begin
          if (cur_phase == PH_RX_OFF) wake_receiver();
          if (l > 1) ck_cmd = CLK_RUN;
          cur_phase = PH_INACTIVE;
        end
        cur_deadline = it.now_ms + idle_time(l);
      end else if (it.now_ms >= cur_deadline && l != '0 && !it.audio_busy) begin
        dwell = TIME_W'(130 - 10 * int'(l));
        case (cur_phase)
          PH_INACTIVE: begin
            cur_deadline = it.now_ms + idle_time(l);
            if (l > 1) ck_cmd = CLK_ECO;
            cur_phase = PH_RX_ON;
          end
          PH_RX_ON: begin
            rx_cmd        = PWR_DOWN;
            rx_codec      = (l > 1);
            cur_codec_off = rx_codec;
            cur_deadline  = it.now_ms + (dwell << (int'(l) - 1));
            cur_phase     = PH_RX_OFF;
          end
          default: begin
            wake_receiver();
            cur_deadline = it.now_ms + dwell;
            rssi_restart = 1'b1;
            cur_phase    = PH_RX_ON;
          end
        endcase
      end
    end
    r.rx_on              = (cur_phase != PH_RX_OFF);
    r.phase              = cur_phase;
    r.rx_power_cmd       = rx_cmd;
    r.include_codec_chip = (rx_cmd != PWR_NONE) ? rx_codec : 1'b0;
    r.clock_cmd          = ck_cmd;
    r.postpone_rssi      = rssi_restart;
    return r;
  endfunction

  function automatic void check_field(input string fname, input logic [APB_W-1:0] want,
                                      input logic [APB_W-1:0] got);
    if (got !== want) begin
      if (mismatch_cnt < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cur_level     = LEVEL_RESET;
      cur_phase     = PH_INACTIVE;
      cur_deadline  = '0;
      cur_codec_off = 1'b0;
      exit_pending  = 1'b0;
      exit_level    = '0;
      mismatch_cnt  = 0;
      awaited_results.delete();
    end else begin
      // register access
      if (psel && penable && pready && paddr[2] == REG_SAVE_LEVEL) begin
        if (pwrite) write_level(pwdata[LEVEL_W-1:0]);
        else check_field("save_level readback", APB_W'(cur_level), prdata);
      end
      // result transaction
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("%0t ns: result transaction with none expected, expected nothing, actual %h",
                     $time, out_data);
          mismatch_cnt++;
        end else begin
          want = awaited_results.pop_front();
          check_field("rx_on", APB_W'(want.rx_on), APB_W'(out_data.rx_on));
          check_field("phase", APB_W'(want.phase), APB_W'(out_data.phase));
          check_field("rx_power_cmd", APB_W'(want.rx_power_cmd),
                      APB_W'(out_data.rx_power_cmd));
          check_field("include_codec_chip", APB_W'(want.include_codec_chip),
                      APB_W'(out_data.include_codec_chip));
          check_field("clock_cmd", APB_W'(want.clock_cmd), APB_W'(out_data.clock_cmd));
          check_field("postpone_rssi", APB_W'(want.postpone_rssi),
                      APB_W'(out_data.postpone_rssi));
        end
      end
      // input transaction
      if (in_valid && !in_stall) awaited_results.push_back(next_power_result(in_data));
    end
    pending <= awaited_results.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for rx_duty_cycle_power_saver_unit
// instantiates the unit and rdcps_checker; depends on rdcps_pkg
module tb_top
  import rdcps_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned NUM_PLANS   = 12;
  // phase code outside the enum, the unit must ignore a force to it
  localparam logic [1:0]  BAD_PHASE   = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_W-1:0]   pwdata;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  // random idling on both sides; off for one whole config phase
  bit idle_on = 1'b1;
  // set by the stimulus to make the receiver hold off, cleared by the receiver
  bit hold_go = 1'b0;
  // running millisecond clock for well-formed poll sequences
  logic [TIME_W-1:0] clock_ms = '0;

  // save_level and transaction count of each config phase; a zero count means
  // the next write follows right away, so after a level-zero write the pending
  // exit meets a second level change
  int unsigned plan_level[NUM_PLANS] = '{5, 0, 2, 7, 0, 3, 6, 0, 4, 7, 0, 1};
  int unsigned plan_items[NUM_PLANS] = '{60, 60, 0, 70, 50, 60, 60, 0, 60, 60, 40, 60};

  rx_duty_cycle_power_saver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  rdcps_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mismatch_cnt (mismatch_cnt),
    .pending      (pending)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request so the unit
  // fills up and pushes back on the input channel
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= idle_on && ($urandom_range(99) < 10);
    end
  end

  function automatic in_item_t make_item(input logic func, input logic [TIME_W-1:0] now,
                                         input logic [1:0] ns, input logic sig,
                                         input logic usr, input logic oth,
                                         input logic hot, input logic aud);
    in_item_t it;
    it.func         = func;
    it.now_ms       = now;
    it.new_state    = ns;
    it.has_signal   = sig;
    it.user_event   = usr;
    it.other_busy   = oth;
    it.hotspot_mode = hot;
    it.audio_busy   = aud;
    return it;
  endfunction

  // mostly polls on an advancing clock with rare activity, some forced
  // phases, a little fully random noise and an occasional clock jump
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [63:0] raw;
    int unsigned pick;
    int unsigned step_pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      raw = {$urandom, $urandom};
      it  = raw[$bits(in_item_t)-1:0];
    end else begin
      step_pick = $urandom_range(99);
      if (step_pick < 60) clock_ms += $urandom_range(150);
      else if (step_pick < 90) clock_ms += $urandom_range(1500, 100);
      else if (step_pick < 99) clock_ms += $urandom_range(13000, 1000);
      else clock_ms = $urandom;
      it = make_item(pick < 11 ? FUNC_FORCE : FUNC_POLL, clock_ms, 2'($urandom_range(3)),
                     $urandom_range(99) < 2, $urandom_range(99) < 2,
                     $urandom_range(99) < 2, $urandom_range(99) < 8,
                     $urandom_range(99) < 8);
    end
    return it;
  endfunction

  // one input transaction, with random idle cycles in front
  task automatic send_item(input in_item_t it);
    while (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every result transaction is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write or read of save_level: setup cycle, then access cycle
  task automatic cfg_access(input logic wr, input logic [APB_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_SAVE_LEVEL, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // level in the low bits, junk above that the unit must ignore
  task automatic set_level(input int unsigned lvl);
    logic [APB_W-1:0] data;
    data = $urandom;
    data[LEVEL_W-1:0] = LEVEL_W'(lvl);
    cfg_access(1'b1, data);
    cfg_access(1'b0, '0);
  endtask

  initial begin
    rst_n   <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of save_level
    cfg_access(1'b0, '0);

    // directed walk at level 1: deadline at zero, duty cycle, audio block,
    // hotspot, each activity flag, forces incl. same phase and the bad code,
    // deadline wrap and the extremes of now_ms
    send_item(make_item(FUNC_POLL, 32'd0, PH_INACTIVE, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_POLL, 32'd9999, PH_INACTIVE, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_POLL, 32'd10000, PH_INACTIVE, 0, 0, 0, 0, 1));
    send_item(make_item(FUNC_POLL, 32'd10000, PH_INACTIVE, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_POLL, 32'd10119, PH_INACTIVE, 0, 0, 0, 1, 0));
    send_item(make_item(FUNC_POLL, 32'd10120, PH_INACTIVE, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_POLL, 32'd10240, PH_INACTIVE, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_POLL, 32'd10300, PH_INACTIVE, 1, 0, 0, 0, 0));
    send_item(make_item(FUNC_POLL, 32'd30000, PH_INACTIVE, 0, 0, 0, 1, 0));
    send_item(make_item(FUNC_POLL, 32'd30000, PH_INACTIVE, 0, 1, 0, 0, 0));
    send_item(make_item(FUNC_POLL, 32'd40000, PH_INACTIVE, 0, 0, 1, 0, 0));
    send_item(make_item(FUNC_FORCE, 32'd40001, PH_RX_OFF, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_FORCE, 32'd40002, PH_RX_OFF, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_FORCE, 32'd40003, BAD_PHASE, 1, 1, 1, 1, 1));
    send_item(make_item(FUNC_FORCE, 32'd40004, PH_RX_ON, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_FORCE, 32'hFFFF_F000, PH_INACTIVE, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_POLL, 32'hFFFF_FFFF, PH_INACTIVE, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_POLL, 32'd0, BAD_PHASE, 1, 1, 1, 1, 1));
    send_item(make_item(FUNC_POLL, 32'hFFFF_FFFF, BAD_PHASE, 1, 1, 1, 1, 1));
    send_item(make_item(FUNC_FORCE, 32'hFFFF_FFFF, PH_RX_OFF, 0, 0, 0, 0, 0));
    drain();

    clock_ms = $urandom_range(100000);
    for (int p = 0; p < NUM_PLANS; p++) begin
      // leave the unit in a saving phase ahead of a zero write, so the
      // write has an exit to hold pending
      if (p == 0 || plan_items[p-1] != 0) begin
        send_item(make_item(FUNC_FORCE, clock_ms,
                            plan_level[p] == 0 ? 2'($urandom_range(2, 1)) :
                                                 2'($urandom_range(2)),
                            0, 0, 0, 0, 0));
        drain();
      end
      set_level(plan_level[p]);
      idle_on = (p != 5);
      for (int n = 0; n < plan_items[p]; n++) begin
        if (n == 20 && (p == 1 || p == 3 || p == 6)) hold_go = 1'b1;
        // sender pause in the middle of a phase
        if (n == 40 && p == 3) drain();
        send_item(random_item());
      end
      if (plan_items[p] != 0) drain();
    end

    if (mismatch_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rdcps_pkg.sv
hw/rtl/rdcps_cfg.sv
hw/rtl/rdcps_step.sv
hw/rtl/rx_duty_cycle_power_saver_unit.sv
tb/rdcps_checker.sv
tb/tb_top.sv
